### sv/rgsa_pkg.sv
// ----------------------------------------------------------------------------
// rgsa_pkg
// Shared widths, register indexes, reset values and the command and status
// types that join the averager controller and datapath.
// ----------------------------------------------------------------------------
package rgsa_pkg;

    // field widths
    localparam int TEMP_SAMPLE_W = 12;
    localparam int HUM_SAMPLE_W  = 11;
    localparam int TEMP_BOUND_W  = 11;
    localparam int HUM_BOUND_W   = 10;
    localparam int COUNT_W       = 16;
    localparam int SUM_W         = 32;
    localparam int PERIOD_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH       = 3'd5;

    // reset values
    localparam logic [PERIOD_W-1:0]            DEF_PERIOD    = 16'd2000;
    localparam logic signed [TEMP_BOUND_W-1:0] DEF_TEMP_LOW  = -11'sd400;
    localparam logic signed [TEMP_BOUND_W-1:0] DEF_TEMP_HIGH = 11'sd800;
    localparam logic [HUM_BOUND_W-1:0]         DEF_HUM_LOW   = 10'd0;
    localparam logic [HUM_BOUND_W-1:0]         DEF_HUM_HIGH  = 10'd1000;

    // count saturation point
    localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'hFFFF;

    // controller to datapath commands
    typedef struct packed {
        logic tick_en;      // tick transaction accepted this cycle
        logic div_start;    // start a division
        logic div_sel_hum;  // 0 = temperature operands, 1 = humidity operands
        logic take_temp;    // capture temperature quotient
        logic take_hum;     // capture humidity quotient
        logic load_res;     // load result into output register
    } rgsa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;     // quotient valid this cycle
    } rgsa_status_t;

endpackage

### sv/rgsa_if.sv
// ----------------------------------------------------------------------------
// rgsa_if
// Valid/ready channels of the averager: request, response and register write.
// ----------------------------------------------------------------------------
interface rgsa_req_if;
    import rgsa_pkg::*;

    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic                            collect;
    logic signed [TEMP_SAMPLE_W-1:0] temp_sample;
    logic                            temp_ok;
    logic [HUM_SAMPLE_W-1:0]         hum_sample;
    logic                            hum_ok;

    modport source (
        output valid, req_type, collect, temp_sample, temp_ok, hum_sample, hum_ok,
        input  ready
    );
    modport sink (
        input  valid, req_type, collect, temp_sample, temp_ok, hum_sample, hum_ok,
        output ready
    );
endinterface

interface rgsa_rsp_if;
    import rgsa_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [TEMP_BOUND_W-1:0] avg_temp;
    logic [HUM_BOUND_W-1:0]         avg_hum;
    logic [COUNT_W-1:0]             temp_samples;
    logic [COUNT_W-1:0]             hum_samples;

    modport source (
        output valid, avg_temp, avg_hum, temp_samples, hum_samples,
        input  ready
    );
    modport sink (
        input  valid, avg_temp, avg_hum, temp_samples, hum_samples,
        output ready
    );
endinterface

interface rgsa_cfg_if;
    import rgsa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### sv/range_gated_sample_averager_unit.sv
// ----------------------------------------------------------------------------
// range_gated_sample_averager_unit
// Range-gated running average of temperature and humidity readings.
// ----------------------------------------------------------------------------
// A tick transaction, while the unit is enabled, updates the period timer
// and the range-gated sums and counts at once. For a query, one restoring
// divider, shared by both channels, produces one quotient bit per cycle,
// first for temperature and then for humidity, and then the output register
// is loaded once it is free. The request channel is busy for the
// whole query, but a finished response may wait in the output register while
// further ticks are accepted. Register writes are accepted every cycle.
module range_gated_sample_averager_unit (
    input  logic       clk,
    input  logic       rst_n,
    rgsa_req_if.sink   req,
    rgsa_rsp_if.source rsp,
    rgsa_cfg_if.sink   cfg
);
    import rgsa_pkg::*;

    rgsa_cmd_t    cmd;
    rgsa_status_t status;

    // register writes never stall
    assign cfg.ready = 1'b1;

    // sequencer
    rgsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_is_query (req.req_type == REQ_QUERY),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // accumulators, divider and result register
    rgsa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .collect      (req.collect),
        .temp_sample  (req.temp_sample),
        .temp_ok      (req.temp_ok),
        .hum_sample   (req.hum_sample),
        .hum_ok       (req.hum_ok),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .avg_temp     (rsp.avg_temp),
        .avg_hum      (rsp.avg_hum),
        .temp_samples (rsp.temp_samples),
        .hum_samples  (rsp.hum_samples)
    );

endmodule

### sv/rgsa_div.sv
// ----------------------------------------------------------------------------
// rgsa_div
// Restoring unsigned divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module rgsa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rgsa_pkg::SUM_W-1:0]    dividend,
    input  logic [rgsa_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [rgsa_pkg::SUM_W-1:0]    quotient
);
    import rgsa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  dvs_reg;

    logic [COUNT_W:0]    rem_shift;
    logic [COUNT_W+1:0]  rem_diff;
    logic                fits;

    // trial subtraction
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = ~rem_diff[COUNT_W+1];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/rgsa_datapath.sv
// ----------------------------------------------------------------------------
// rgsa_datapath
// Configuration registers, range-gated accumulators, period timer, the
// shared divider and the result register of the averager.
// ----------------------------------------------------------------------------
module rgsa_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rgsa_pkg::rgsa_cmd_t                   cmd,
    output rgsa_pkg::rgsa_status_t                status,
    // tick payload
    input  logic                                  collect,
    input  logic signed [rgsa_pkg::TEMP_SAMPLE_W-1:0] temp_sample,
    input  logic                                  temp_ok,
    input  logic [rgsa_pkg::HUM_SAMPLE_W-1:0]     hum_sample,
    input  logic                                  hum_ok,
    // register writes
    input  logic                                  cfg_we,
    input  logic [rgsa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rgsa_pkg::CFG_DATA_W-1:0]       cfg_data,
    // result register
    output logic signed [rgsa_pkg::TEMP_BOUND_W-1:0] avg_temp,
    output logic [rgsa_pkg::HUM_BOUND_W-1:0]      avg_hum,
    output logic [rgsa_pkg::COUNT_W-1:0]          temp_samples,
    output logic [rgsa_pkg::COUNT_W-1:0]          hum_samples
);
    import rgsa_pkg::*;

    // configuration
    logic                           enabled_reg;
    logic [PERIOD_W-1:0]            period_reg;
    logic signed [TEMP_BOUND_W-1:0] temp_low_reg;
    logic signed [TEMP_BOUND_W-1:0] temp_high_reg;
    logic [HUM_BOUND_W-1:0]         hum_low_reg;
    logic [HUM_BOUND_W-1:0]         hum_high_reg;

    // accumulation state
    logic [SUM_W-1:0]    temp_sum_reg,   temp_sum_next;
    logic [SUM_W-1:0]    hum_sum_reg,    hum_sum_next;
    logic [COUNT_W-1:0]  temp_count_reg, temp_count_next;
    logic [COUNT_W-1:0]  hum_count_reg,  hum_count_next;
    logic [PERIOD_W-1:0] timer_reg,      timer_next;
    logic                last_collect_reg, last_collect_next;

    // quotient holding and result registers
    logic signed [TEMP_BOUND_W-1:0] avg_temp_hold_reg;
    logic [HUM_BOUND_W-1:0]         avg_hum_hold_reg;
    logic signed [TEMP_BOUND_W-1:0] res_temp_reg;
    logic [HUM_BOUND_W-1:0]         res_hum_reg;
    logic [COUNT_W-1:0]             res_temp_cnt_reg;
    logic [COUNT_W-1:0]             res_hum_cnt_reg;

    logic                           clear_acc;
    logic [PERIOD_W-1:0]            period_eff;
    logic [PERIOD_W-1:0]            timer_inc;
    logic                           sample_hit;
    logic signed [TEMP_SAMPLE_W-1:0] temp_low_x;
    logic signed [TEMP_SAMPLE_W-1:0] temp_high_x;
    logic                           temp_take;
    logic                           hum_take;
    logic                           temp_neg;
    logic [SUM_W-1:0]               temp_mag;
    logic [SUM_W-1:0]               div_dividend;
    logic [COUNT_W-1:0]             div_divisor;
    logic                           div_done;
    logic [SUM_W-1:0]               div_quo;
    logic [TEMP_BOUND_W-1:0]        temp_q;

    // register writes; enabling from disabled clears accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            period_reg    <= DEF_PERIOD;
            temp_low_reg  <= DEF_TEMP_LOW;
            temp_high_reg <= DEF_TEMP_HIGH;
            hum_low_reg   <= DEF_HUM_LOW;
            hum_high_reg  <= DEF_HUM_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLED:        enabled_reg   <= cfg_data[0];
                REG_MEASURE_PERIOD: period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_TEMP_LOW:       temp_low_reg  <= cfg_data[TEMP_BOUND_W-1:0];
                REG_TEMP_HIGH:      temp_high_reg <= cfg_data[TEMP_BOUND_W-1:0];
                REG_HUM_LOW:        hum_low_reg   <= cfg_data[HUM_BOUND_W-1:0];
                REG_HUM_HIGH:       hum_high_reg  <= cfg_data[HUM_BOUND_W-1:0];
                default:            ;
            endcase
        end
    end

    assign clear_acc = cfg_we && (cfg_index == REG_ENABLED) && cfg_data[0] && !enabled_reg;

    // period timer and window checks
    assign period_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign timer_inc   = timer_reg + 1'b1;
    assign sample_hit  = collect && (timer_inc >= period_eff);
    assign temp_low_x  = {temp_low_reg[TEMP_BOUND_W-1], temp_low_reg};
    assign temp_high_x = {temp_high_reg[TEMP_BOUND_W-1], temp_high_reg};
    assign temp_take   = sample_hit && temp_ok
                      && (temp_sample >= temp_low_x) && (temp_sample <= temp_high_x)
                      && (temp_count_reg != MAX_SAMPLES);
    assign hum_take    = sample_hit && hum_ok
                      && (hum_sample >= {1'b0, hum_low_reg})
                      && (hum_sample <= {1'b0, hum_high_reg})
                      && (hum_count_reg != MAX_SAMPLES);

    // tick update: a rising collect clears, otherwise timer and samples
    always_comb
    begin
        temp_sum_next     = temp_sum_reg;
        hum_sum_next      = hum_sum_reg;
        temp_count_next   = temp_count_reg;
        hum_count_next    = hum_count_reg;
        timer_next        = timer_reg;
        last_collect_next = last_collect_reg;
        if (clear_acc)
        begin
            temp_sum_next   = '0;
            hum_sum_next    = '0;
            temp_count_next = '0;
            hum_count_next  = '0;
            timer_next      = '0;
        end
        else if (cmd.tick_en && enabled_reg)
        begin
            last_collect_next = collect;
            if (collect && !last_collect_reg)
            begin
                temp_sum_next   = '0;
                hum_sum_next    = '0;
                temp_count_next = '0;
                hum_count_next  = '0;
                timer_next      = '0;
            end
            else if (collect)
            begin
                timer_next = sample_hit ? '0 : timer_inc;
                if (temp_take)
                begin
                    temp_sum_next   = temp_sum_reg
                                    + {{(SUM_W-TEMP_SAMPLE_W){temp_sample[TEMP_SAMPLE_W-1]}},
                                       temp_sample};
                    temp_count_next = temp_count_reg + 1'b1;
                end
                if (hum_take)
                begin
                    hum_sum_next   = hum_sum_reg + {{(SUM_W-HUM_SAMPLE_W){1'b0}}, hum_sample};
                    hum_count_next = hum_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_sum_reg     <= '0;
            hum_sum_reg      <= '0;
            temp_count_reg   <= '0;
            hum_count_reg    <= '0;
            timer_reg        <= '0;
            last_collect_reg <= 1'b0;
        end
        else
        begin
            temp_sum_reg     <= temp_sum_next;
            hum_sum_reg      <= hum_sum_next;
            temp_count_reg   <= temp_count_next;
            hum_count_reg    <= hum_count_next;
            timer_reg        <= timer_next;
            last_collect_reg <= last_collect_next;
        end
    end

    // divider operands: magnitude of the temperature sum, sign restored after
    assign temp_neg     = temp_sum_reg[SUM_W-1];
    assign temp_mag     = temp_neg ? (~temp_sum_reg + 1'b1) : temp_sum_reg;
    assign div_dividend = cmd.div_sel_hum ? hum_sum_reg : temp_mag;
    assign div_divisor  = cmd.div_sel_hum ? hum_count_reg : temp_count_reg;

    rgsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign status.div_done = div_done;
    assign temp_q = temp_neg ? (~div_quo[TEMP_BOUND_W-1:0] + 1'b1) : div_quo[TEMP_BOUND_W-1:0];

    // quotient capture, zero when disabled or no samples
    always_ff @(posedge clk)
    begin
        if (cmd.take_temp)
        begin
            avg_temp_hold_reg <= (enabled_reg && temp_count_reg != '0) ? temp_q : '0;
        end
        if (cmd.take_hum)
        begin
            avg_hum_hold_reg <= (enabled_reg && hum_count_reg != '0)
                              ? div_quo[HUM_BOUND_W-1:0] : '0;
        end
        if (cmd.load_res)
        begin
            res_temp_reg     <= avg_temp_hold_reg;
            res_hum_reg      <= avg_hum_hold_reg;
            res_temp_cnt_reg <= enabled_reg ? temp_count_reg : '0;
            res_hum_cnt_reg  <= enabled_reg ? hum_count_reg : '0;
        end
    end

    assign avg_temp     = res_temp_reg;
    assign avg_hum      = res_hum_reg;
    assign temp_samples = res_temp_cnt_reg;
    assign hum_samples  = res_hum_cnt_reg;

endmodule

### sv/rgsa_ctrl.sv
// ----------------------------------------------------------------------------
// rgsa_ctrl
// Sequencer of the averager: takes transactions, runs the two divisions of a
// query and hands the result to the output register.
// ----------------------------------------------------------------------------
module rgsa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_is_query,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  rgsa_pkg::rgsa_status_t status,
    output rgsa_pkg::rgsa_cmd_t    cmd
);
    import rgsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_TEMP,
        S_DIV_HUM,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !in_is_query)
                begin
                    cmd.tick_en = 1'b1;
                end
                else if (in_fire)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_TEMP;
                end
            end
            S_DIV_TEMP:
            begin
                if (status.div_done)
                begin
                    cmd.take_temp   = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_hum = 1'b1;
                    state_next      = S_DIV_HUM;
                end
            end
            S_DIV_HUM:
            begin
                cmd.div_sel_hum = 1'b1;
                if (status.div_done)
                begin
                    cmd.take_hum = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_res   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a query transaction always starts the temperature division
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_is_query) |=> (state_reg == S_DIV_TEMP))
        else $error("query did not start division");

    // the result register is never overwritten while its result is pending
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before delivery");

    // a response appears only after a load
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_res))
        else $error("response valid without load");

    // a tick never runs alongside a division
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_en |-> (state_reg == S_IDLE && !cmd.div_start))
        else $error("tick taken while busy");

endmodule
